// ----- rtl/ofpe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofpe_pkg - optical-flow position estimator package
// Shared types, register codes, reset values and helpers.
// ----------------------------------------------------------------------------
package ofpe_pkg;

  // time field width default (legal range 16..32)
  localparam int TIME_WIDTH_DEF = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUALITY_MIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GROUND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GROUND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONF_MAX    = 3'd4;

  localparam logic [15:0] RST_STALE_LIMIT = 16'd200;
  localparam logic [7:0]  RST_QUALITY_MIN = 8'd40;
  localparam logic [15:0] RST_MIN_GROUND  = 16'd300;
  localparam logic [15:0] RST_MAX_GROUND  = 16'd4500;
  localparam logic [3:0]  RST_CONF_MAX    = 4'd10;

  // 100 * |delta altitude| fits in 23 bits
  localparam int MAG_W = 23;

  localparam logic [15:0] VZ_POS_SAT = 16'h7FFF;
  localparam logic [15:0] VZ_NEG_SAT = 16'h8000;

  typedef logic [3:0] conf_t;

  typedef struct packed {
    logic [15:0] stale_limit;
    logic [7:0]  quality_min;
    logic [15:0] min_ground;
    logic [15:0] max_ground;
    conf_t       conf_max;
  } cfg_t;

  // per-item classification from the front end
  typedef struct packed {
    logic stale;
    logic qual_ok;
    logic gnd_ok;
  } cls_t;

  // confidence scaled by one hundred
  function automatic logic [10:0] conf_x100(input conf_t c);
    conf_x100 = {7'd0, c} * 11'd100;
  endfunction

  // saturating increment below the limit
  function automatic conf_t conf_inc(input conf_t c, input conf_t lim);
    conf_inc = (c < lim) ? c + 4'd1 : c;
  endfunction

endpackage : ofpe_pkg
`default_nettype wire

// ----- rtl/ofpe_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofpe_in_if - flow report channel
// Valid/ready channel carrying one optical-flow report per transfer.
// ----------------------------------------------------------------------------
interface ofpe_in_if #(
  parameter int TIME_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] now_ms;
  logic                  flow_valid;
  logic [TIME_WIDTH-1:0] flow_time_ms;
  logic [7:0]            flow_quality;
  logic signed [15:0]    flow_x_cm_s;
  logic signed [15:0]    flow_y_cm_s;
  logic [15:0]           ground_dist_mm;

  modport source (
    output valid, now_ms, flow_valid, flow_time_ms, flow_quality,
           flow_x_cm_s, flow_y_cm_s, ground_dist_mm,
    input  ready
  );
  modport sink (
    input  valid, now_ms, flow_valid, flow_time_ms, flow_quality,
           flow_x_cm_s, flow_y_cm_s, ground_dist_mm,
    output ready
  );
endinterface : ofpe_in_if
`default_nettype wire

// ----- rtl/ofpe_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofpe_out_if - estimate channel
// Valid/ready channel carrying one position estimate per transfer.
// ----------------------------------------------------------------------------
interface ofpe_out_if #(
  parameter int TIME_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [10:0]           horiz_conf_x100;
  logic [10:0]           vert_conf_x100;
  logic [15:0]           alt_mm;
  logic signed [15:0]    vx_cm_s;
  logic signed [15:0]    vy_cm_s;
  logic signed [15:0]    vz_cm_s;
  logic [TIME_WIDTH-1:0] time_ms;

  modport source (
    output valid, horiz_conf_x100, vert_conf_x100, alt_mm, vx_cm_s, vy_cm_s,
           vz_cm_s, time_ms,
    input  ready
  );
  modport sink (
    input  valid, horiz_conf_x100, vert_conf_x100, alt_mm, vx_cm_s, vy_cm_s,
           vz_cm_s, time_ms,
    output ready
  );
endinterface : ofpe_out_if
`default_nettype wire

// ----- rtl/ofpe_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofpe_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ofpe_cfg_if;
  import ofpe_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface : ofpe_cfg_if
`default_nettype wire

// ----- rtl/ofpe_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofpe_front - report intake and classification
// Takes flow reports, flags stale/quality/ground, computes elapsed time.
// ----------------------------------------------------------------------------
module ofpe_front import ofpe_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int ENT_W      = 2 * TIME_WIDTH + 51
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  ofpe_in_if.sink               in_ch,
  input  wire logic             q_full,
  output logic                  q_push,
  output logic [ENT_W-1:0]      q_data
);

  logic [TIME_WIDTH-1:0] last_time_r;
  logic [TIME_WIDTH-1:0] last_time_nxt;
  logic [TIME_WIDTH-1:0] age;
  logic [TIME_WIDTH-1:0] dt;
  logic [TIME_WIDTH-1:0] lim;
  cls_t                  cls;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // report age and elapsed time since the previous estimate, both wrapping
  assign age = in_ch.now_ms - in_ch.flow_time_ms;
  assign dt  = in_ch.now_ms - last_time_r;
  assign lim = TIME_WIDTH'(cfg.stale_limit);

  // classification
  always_comb begin
    cls.stale   = !in_ch.flow_valid || (age > lim);
    cls.qual_ok = in_ch.flow_quality > cfg.quality_min;
    cls.gnd_ok  = (in_ch.ground_dist_mm > cfg.min_ground) &&
                  (in_ch.ground_dist_mm < cfg.max_ground);
  end

  assign q_data = {cls, in_ch.now_ms, dt, in_ch.flow_x_cm_s, in_ch.flow_y_cm_s,
                   in_ch.ground_dist_mm};

  // previous estimate time
  assign last_time_nxt = q_push ? in_ch.now_ms : last_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
    end else begin
      last_time_r <= last_time_nxt;
    end
  end

endmodule : ofpe_front
`default_nettype wire

// ----- rtl/ofpe_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofpe_queue - two-entry queue
// Decouples the classification front end from the estimator back end.
// ----------------------------------------------------------------------------
module ofpe_queue #(
  parameter int DW = 115
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  input  wire logic          pop,
  output logic [DW-1:0]      pop_data,
  output logic               full,
  output logic               empty
);

  logic [DW-1:0] mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : ofpe_queue
`default_nettype wire

// ----- rtl/ofpe_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofpe_back - estimator state and vertical-speed divider
// Updates confidences, velocities and altitude, one bit of quotient a cycle.
// ----------------------------------------------------------------------------
module ofpe_back import ofpe_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int ENT_W      = 2 * TIME_WIDTH + 51
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             q_empty,
  input  wire logic [ENT_W-1:0] q_data,
  output logic                  q_pop,
  ofpe_out_if.source            out_ch
);

  localparam int CNT_W = $clog2(MAG_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // queue entry fields
  cls_t                  e_cls;
  logic [TIME_WIDTH-1:0] e_now;
  logic [TIME_WIDTH-1:0] e_dt;
  logic [15:0]           e_fx;
  logic [15:0]           e_fy;
  logic [15:0]           e_gnd;

  assign {e_cls, e_now, e_dt, e_fx, e_fy, e_gnd} = q_data;

  logic [1:0]            st_r;
  conf_t                 hconf_r;
  conf_t                 vconf_r;
  logic [15:0]           vx_r;
  logic [15:0]           vy_r;
  logic [15:0]           vz_r;
  logic [15:0]           alt_r;
  logic [TIME_WIDTH-1:0] tm_r;

  // divider
  logic [TIME_WIDTH-1:0] divisor_r;
  logic [TIME_WIDTH-1:0] rem_r;
  logic [MAG_W-1:0]      dvd_r;
  logic [MAG_W-1:0]      quo_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  neg_r;

  // output register
  logic                  ovld_r;
  logic [10:0]           o_hc_r;
  logic [10:0]           o_vc_r;
  logic [15:0]           o_alt_r;
  logic [15:0]           o_vx_r;
  logic [15:0]           o_vy_r;
  logic [15:0]           o_vz_r;
  logic [TIME_WIDTH-1:0] o_tm_r;

  logic                  out_free;

  // pop-time combinational update
  conf_t                 h0;
  conf_t                 v0;
  logic                  neg;
  logic [15:0]           diff;
  logic [MAG_W-1:0]      mag;
  logic                  need_div;

  // divider step
  logic [TIME_WIDTH:0]   rem_sh;
  logic                  qbit;
  logic [TIME_WIDTH-1:0] rem_step;
  logic [MAG_W-1:0]      q_fin;
  logic [15:0]           vz_div;

  assign q_pop    = (st_r == ST_IDLE) && !q_empty;
  assign out_free = !ovld_r || out_ch.ready;

  assign h0   = e_cls.stale ? 4'd0 : hconf_r;
  assign v0   = e_cls.stale ? 4'd0 : vconf_r;
  assign neg  = e_gnd < alt_r;
  assign diff = neg ? (alt_r - e_gnd) : (e_gnd - alt_r);
  assign mag  = MAG_W'({7'd0, diff} * 23'd100);

  // serial division only for a real change over a nonzero interval
  assign need_div = e_cls.gnd_ok && (v0 != 4'd0) && (mag != '0) && (e_dt != '0);

  // restoring division step
  assign rem_sh   = {rem_r, dvd_r[MAG_W-1]};
  assign qbit     = rem_sh >= {1'b0, divisor_r};
  assign rem_step = qbit ? TIME_WIDTH'(rem_sh - {1'b0, divisor_r})
                         : rem_sh[TIME_WIDTH-1:0];
  assign q_fin    = {quo_r[MAG_W-2:0], qbit};

  // signed saturation of the quotient
  always_comb begin
    if (neg_r) begin
      vz_div = (q_fin >= MAG_W'(32768)) ? VZ_NEG_SAT : (16'd0 - q_fin[15:0]);
    end else begin
      vz_div = (q_fin > MAG_W'(32767)) ? VZ_POS_SAT : q_fin[15:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      hconf_r <= '0;
      vconf_r <= '0;
      vx_r    <= '0;
      vy_r    <= '0;
      vz_r    <= '0;
      alt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      if ((st_r == ST_DONE) && out_free) begin
        ovld_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovld_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (!q_empty) begin
            st_r <= need_div ? ST_DIV : ST_DONE;
            if (e_cls.qual_ok) begin
              vx_r    <= e_fx;
              vy_r    <= e_fy;
              hconf_r <= conf_inc(h0, cfg.conf_max);
            end else begin
              vx_r    <= '0;
              vy_r    <= '0;
              hconf_r <= '0;
            end
            if (e_cls.gnd_ok) begin
              alt_r   <= e_gnd;
              vconf_r <= conf_inc(v0, cfg.conf_max);
              if (v0 != 4'd0) begin
                if (mag == '0) begin
                  vz_r <= '0;
                end else if (e_dt == '0) begin
                  vz_r <= neg ? VZ_NEG_SAT : VZ_POS_SAT;
                end
              end
            end else begin
              alt_r   <= '0;
              vconf_r <= '0;
              vz_r    <= '0;
            end
          end
        end
        ST_DIV: begin
          if (cnt_r == '0) begin
            vz_r <= vz_div;
            st_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            st_r <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  // divider datapath and item time
  always_ff @(posedge clk) begin
    if (q_pop) begin
      tm_r      <= e_now;
      divisor_r <= e_dt;
      rem_r     <= '0;
      dvd_r     <= mag;
      quo_r     <= '0;
      cnt_r     <= CNT_W'(MAG_W - 1);
      neg_r     <= neg;
    end else if (st_r == ST_DIV) begin
      rem_r <= rem_step;
      dvd_r <= {dvd_r[MAG_W-2:0], 1'b0};
      quo_r <= q_fin;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if ((st_r == ST_DONE) && out_free) begin
      o_hc_r  <= conf_x100(hconf_r);
      o_vc_r  <= conf_x100(vconf_r);
      o_alt_r <= alt_r;
      o_vx_r  <= vx_r;
      o_vy_r  <= vy_r;
      o_vz_r  <= vz_r;
      o_tm_r  <= tm_r;
    end
  end

  assign out_ch.valid           = ovld_r;
  assign out_ch.horiz_conf_x100 = o_hc_r;
  assign out_ch.vert_conf_x100  = o_vc_r;
  assign out_ch.alt_mm          = o_alt_r;
  assign out_ch.vx_cm_s         = o_vx_r;
  assign out_ch.vy_cm_s         = o_vy_r;
  assign out_ch.vz_cm_s         = o_vz_r;
  assign out_ch.time_ms         = o_tm_r;

endmodule : ofpe_back
`default_nettype wire

// ----- rtl/optflow_position_estimator.sv -----
// An input transfer is queued; the back end pops it when idle, runs its
// single serial divider when a vertical speed division is needed, and
// registers the result on the output once that is free. It takes no new
// item until the last has left its done state. A two-entry queue lets input
// transfers continue while a result waits. Reset (rst_n, synchronous) clears
// state, counters and valid flags and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// optflow_position_estimator - optical-flow position estimator top level
// Configuration registers, front end, queue and estimator back end.
// ----------------------------------------------------------------------------
module optflow_position_estimator import ofpe_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ofpe_in_if.sink    in_ch,
  ofpe_out_if.source out_ch,
  ofpe_cfg_if.sink   cfg_ch
);

  localparam int ENT_W = 2 * TIME_WIDTH + 51;

  cfg_t             cfg_r;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [ENT_W-1:0] q_wdata;
  logic [ENT_W-1:0] q_rdata;

  // configuration registers, always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stale_limit <= RST_STALE_LIMIT;
      cfg_r.quality_min <= RST_QUALITY_MIN;
      cfg_r.min_ground  <= RST_MIN_GROUND;
      cfg_r.max_ground  <= RST_MAX_GROUND;
      cfg_r.conf_max    <= RST_CONF_MAX;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_STALE_LIMIT: cfg_r.stale_limit <= cfg_ch.data;
        REG_QUALITY_MIN: cfg_r.quality_min <= cfg_ch.data[7:0];
        REG_MIN_GROUND:  cfg_r.min_ground  <= cfg_ch.data;
        REG_MAX_GROUND:  cfg_r.max_ground  <= cfg_ch.data;
        REG_CONF_MAX:    cfg_r.conf_max    <= cfg_ch.data[3:0];
        default: begin
        end
      endcase
    end
  end

  ofpe_front #(
    .TIME_WIDTH (TIME_WIDTH),
    .ENT_W      (ENT_W)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  ofpe_queue #(
    .DW (ENT_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  ofpe_back #(
    .TIME_WIDTH (TIME_WIDTH),
    .ENT_W      (ENT_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule : optflow_position_estimator
`default_nettype wire
